// ----- sv/tkn_pkg.sv -----
`default_nettype none

package tkn_pkg;

  // Built capacity of the selector and the widths that follow from it.
  localparam int MAX_K  = 32;
  localparam int CNT_W  = $clog2(MAX_K + 1);
  localparam int IDX_W  = (MAX_K > 1) ? $clog2(MAX_K) : 1;

  // Field widths of the beats.
  localparam int KIND_W = 2;
  localparam int PAGE_W = 32;
  localparam int SLOT_W = 16;
  localparam int DIST_W = 32;
  localparam int HELD_W = 6;
  localparam int K_W    = 6;

  // Register port.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_K_IN_USE = 1'b0;
  localparam logic [K_W-1:0] K_RESET = K_W'(32);

  // Request codes.
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH  = 2'd0,
    KIND_DRAIN = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  // One stored candidate.
  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [SLOT_W-1:0] slot;
    logic [DIST_W-1:0] distance;
  } entry_t;

  // What every cell of the chain does in a cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   cand;
  } cell_ctrl_t;

  // Contents of the output register.
  typedef struct packed {
    logic              is_entry;
    logic [PAGE_W-1:0] out_page;
    logic [SLOT_W-1:0] out_slot;
    logic [DIST_W-1:0] out_distance;
    logic [DIST_W-1:0] threshold;
    logic              threshold_infinite;
    logic [HELD_W-1:0] held_after;
    logic              admitted;
    logic              last;
  } rsp_t;

endpackage

`default_nettype wire

// ----- sv/tkn_in_if.sv -----
`default_nettype none

interface tkn_in_if;
  import tkn_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [PAGE_W-1:0] page_number;
  logic [SLOT_W-1:0] entry_slot;
  logic [DIST_W-1:0] distance;

  modport source (output valid, output kind, output page_number, output entry_slot,
                  output distance, input ready);
  modport sink (input valid, input kind, input page_number, input entry_slot,
                input distance, output ready);
endinterface

`default_nettype wire

// ----- sv/tkn_out_if.sv -----
`default_nettype none

interface tkn_out_if;
  import tkn_pkg::*;

  logic              valid;
  logic              ready;
  logic              is_entry;
  logic [PAGE_W-1:0] out_page;
  logic [SLOT_W-1:0] out_slot;
  logic [DIST_W-1:0] out_distance;
  logic [DIST_W-1:0] threshold;
  logic              threshold_infinite;
  logic [HELD_W-1:0] held_after;
  logic              admitted;
  logic              last;

  modport source (output valid, output is_entry, output out_page, output out_slot,
                  output out_distance, output threshold, output threshold_infinite,
                  output held_after, output admitted, output last, input ready);
  modport sink (input valid, input is_entry, input out_page, input out_slot,
                input out_distance, input threshold, input threshold_infinite,
                input held_after, input admitted, input last, output ready);
endinterface

`default_nettype wire

// ----- sv/tkn_cell.sv -----
`default_nettype none

module tkn_cell (
  input  logic               clk,
  input  tkn_pkg::cell_ctrl_t ctrl,
  input  logic               live,
  input  logic               wr_en,
  input  logic               left_gt,
  input  tkn_pkg::entry_t    left_ent,
  input  tkn_pkg::entry_t    right_ent,
  output logic               gt,
  output tkn_pkg::entry_t    ent
);
  import tkn_pkg::*;

  // An empty cell counts as further away than any candidate, so the
  // comparison results along the chain form a thermometer.
  assign gt = !live || (ent.distance > ctrl.cand.distance);

  // Insert: the cells past the insertion point take their left neighbour,
  // the first one past it takes the candidate. Shift moves towards cell 0.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_INSERT: begin
        if (wr_en) begin
          if (left_gt) begin
            ent <= left_ent;
          end else if (gt) begin
            ent <= ctrl.cand;
          end
        end
      end
      CELL_SHIFT: begin
        ent <= right_ent;
      end
      default: begin
        ent <= ent;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/tkn_cfg.sv -----
`default_nettype none

module tkn_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tkn_pkg::APB_AW-1:0] paddr,
  input  logic [tkn_pkg::APB_DW-1:0] pwdata,
  output logic [tkn_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output logic [tkn_pkg::CNT_W-1:0]  k_eff
);
  import tkn_pkg::*;

  logic [K_W-1:0]       k_in_use;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 reg_hit;

  // Registers sit on four-byte boundaries.
  assign reg_idx = paddr[APB_AW-1:2];
  assign reg_hit = (reg_idx == REG_K_IN_USE);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_in_use <= K_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      k_in_use <= pwdata[K_W-1:0];
    end
  end

  assign prdata = reg_hit ? APB_DW'(k_in_use) : '0;

  // Zero acts as one, anything above the built capacity as the capacity.
  always_comb begin
    if (k_in_use == '0) begin
      k_eff = CNT_W'(1);
    end else if (int'(k_in_use) > MAX_K) begin
      k_eff = CNT_W'(MAX_K);
    end else begin
      k_eff = CNT_W'(k_in_use);
    end
  end

endmodule

`default_nettype wire

// ----- sv/top_k_nearest_selector.sv -----
`default_nettype none

// Nearest-candidate selector. Keeps up to k_in_use (at most 32) candidates
// ordered by distance in a chain of cells, one entry per cell.
// Input channel item: kind 0 pushes a candidate, kind 1 drains the store in
// ascending distance order, kind 2 clears it, kind 3 only reports.
// Output channel result: one beat per push, clear, report or empty drain, and
// one beat per held entry for a drain, the final beat marked by last. Every
// beat reports the threshold and the number of entries held after the request.
// Register k_in_use sits at byte address 0 of the APB port; write it only
// while the selector is idle.
// A push or clear is registered as a pending beat when taken; that beat is
// loaded into the output register once the register is empty or being
// emptied, and the result is offered from there.
// Pushes are taken one per cycle while the output register is not stalled:
// all cells compare against the candidate in parallel and insert it in the
// same cycle. A drain of n entries shifts the chain once per beat and holds
// item.ready low until its last beat has left the chain.
// When result.ready is low the output register holds its beat; one further
// request may be taken and waits as a pending beat, after which item.ready
// stays low. Reset empties the store and the output and sets k_in_use to 32.

module top_k_nearest_selector (
  input  logic                       clk,
  input  logic                       rst,
  tkn_in_if.sink                     item,
  tkn_out_if.source                  result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tkn_pkg::APB_AW-1:0] paddr,
  input  logic [tkn_pkg::APB_DW-1:0] pwdata,
  output logic [tkn_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import tkn_pkg::*;

  logic [CNT_W-1:0] k_eff;
  logic [CNT_W-1:0] held;
  logic [CNT_W-1:0] held_next;
  logic [CNT_W-1:0] drain_left;
  logic [CNT_W-1:0] limit;
  logic [IDX_W-1:0] top_idx;
  logic [DIST_W-1:0] top_dist;
  logic             pending;
  logic             pend_adm;
  logic             out_valid;
  rsp_t             out_reg;
  rsp_t             load_val;
  logic             load_fire;
  logic             accept;
  logic             full;
  logic             admit;
  cell_ctrl_t       ctrl;
  entry_t           ent [MAX_K];
  logic             gt  [MAX_K];

  tkn_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .k_eff   (k_eff)
  );

  // Largest held distance sits in the last live cell.
  assign top_idx  = IDX_W'(held - 1'b1);
  assign top_dist = ent[top_idx].distance;

  // Admission: free room, or a strictly nearer candidate that evicts the top.
  assign full  = (held >= k_eff);
  assign admit = !full || ((held != '0) && (item.distance < top_dist));
  assign limit = full ? (held - 1'b1) : held;

  // The output register takes a new beat when it is empty or being emptied.
  assign load_fire  = (!out_valid || result.ready) && ((drain_left != '0) || pending);
  assign item.ready = (drain_left == '0) && (!pending || load_fire);
  assign accept     = item.valid && item.ready;

  // Chain control.
  always_comb begin
    ctrl.cand = '{page: item.page_number, slot: item.entry_slot,
                  distance: item.distance};
    if (load_fire && (drain_left != '0)) begin
      ctrl.op = CELL_SHIFT;
    end else if (accept && (item.kind == KIND_PUSH) && admit) begin
      ctrl.op = CELL_INSERT;
    end else begin
      ctrl.op = CELL_HOLD;
    end
  end

  // Chain of cells.
  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    tkn_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .live      (CNT_W'(i) < held),
      .wr_en     (CNT_W'(i) <= limit),
      .left_gt   ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i - 1]),
      .left_ent  (ent[(i == 0) ? 0 : i - 1]),
      .right_ent (ent[(i == MAX_K - 1) ? i : i + 1]),
      .gt        (gt[i]),
      .ent       (ent[i])
    );
  end

  // Held count after the accepted request.
  always_comb begin
    held_next = held;
    if (accept) begin
      case (item.kind)
        KIND_PUSH: begin
          if (admit && !full) begin
            held_next = held + 1'b1;
          end
        end
        KIND_DRAIN, KIND_CLEAR: begin
          held_next = '0;
        end
        default: begin
          held_next = held;
        end
      endcase
    end
  end

  // Bookkeeping of held entries, drain progress and the pending beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      held       <= '0;
      drain_left <= '0;
      pending    <= 1'b0;
      pend_adm   <= 1'b0;
    end else begin
      held <= held_next;
      if (load_fire && (drain_left != '0)) begin
        drain_left <= drain_left - 1'b1;
      end
      if (accept) begin
        if ((item.kind == KIND_DRAIN) && (held != '0)) begin
          drain_left <= held;
          pending    <= 1'b0;
        end else begin
          pending <= 1'b1;
        end
        pend_adm <= (item.kind == KIND_PUSH) && admit;
      end else if (load_fire && (drain_left == '0)) begin
        pending <= 1'b0;
      end
    end
  end

  // Next beat: a drained entry from the head of the chain, or the report
  // of the last request, which sees the store as it left it.
  always_comb begin
    if (drain_left != '0) begin
      load_val.is_entry           = 1'b1;
      load_val.out_page           = ent[0].page;
      load_val.out_slot           = ent[0].slot;
      load_val.out_distance       = ent[0].distance;
      load_val.threshold          = '1;
      load_val.threshold_infinite = 1'b1;
      load_val.held_after         = '0;
      load_val.admitted           = 1'b0;
      load_val.last               = (drain_left == CNT_W'(1));
    end else begin
      load_val.is_entry           = 1'b0;
      load_val.out_page           = '0;
      load_val.out_slot           = '0;
      load_val.out_distance       = '0;
      load_val.threshold          = (held == '0) ? '1 : top_dist;
      load_val.threshold_infinite = (held == '0);
      load_val.held_after         = HELD_W'(held);
      load_val.admitted           = pend_adm;
      load_val.last               = 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_fire) begin
      out_reg <= load_val;
    end
  end

  assign result.valid              = out_valid;
  assign result.is_entry           = out_reg.is_entry;
  assign result.out_page           = out_reg.out_page;
  assign result.out_slot           = out_reg.out_slot;
  assign result.out_distance       = out_reg.out_distance;
  assign result.threshold          = out_reg.threshold;
  assign result.threshold_infinite = out_reg.threshold_infinite;
  assign result.held_after         = out_reg.held_after;
  assign result.admitted           = out_reg.admitted;
  assign result.last               = out_reg.last;

endmodule

`default_nettype wire

// ----- sv/tkn_checker.sv -----
`default_nettype none

module tkn_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       item_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic                       rsp_is_entry,
  input logic [tkn_pkg::DIST_W-1:0] rsp_threshold,
  input logic                       rsp_threshold_infinite,
  input logic [tkn_pkg::HELD_W-1:0] rsp_held_after,
  input logic                       rsp_admitted,
  input logic                       rsp_last
);
  import tkn_pkg::*;

  // An infinite threshold goes with an empty store and the all-ones value.
  a_thr_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((rsp_threshold_infinite == (rsp_held_after == '0)) &&
                   (!rsp_threshold_infinite || (rsp_threshold == '1))))
    else $error("threshold does not match held count");

  // Never more entries than the chain has cells.
  a_held_max: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (int'(rsp_held_after) <= MAX_K))
    else $error("held count beyond capacity");

  // A drained entry leaves an empty store and admits nothing.
  a_drain_beat: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_is_entry) |-> (rsp_threshold_infinite && !rsp_admitted))
    else $error("drain beat with stale state");

  // No request is taken while a drain still has entries to deliver.
  a_drain_block: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_is_entry && !rsp_last) |-> !item_ready)
    else $error("request taken in the middle of a drain");

  // A held beat stays until it is taken.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_last) &&
                                   $stable(rsp_held_after)))
    else $error("result beat changed while stalled");

endmodule

bind top_k_nearest_selector tkn_checker u_tkn_checker (
  .clk                    (clk),
  .rst                    (rst),
  .item_ready             (item.ready),
  .rsp_valid              (result.valid),
  .rsp_ready              (result.ready),
  .rsp_is_entry           (result.is_entry),
  .rsp_threshold          (result.threshold),
  .rsp_threshold_infinite (result.threshold_infinite),
  .rsp_held_after         (result.held_after),
  .rsp_admitted           (result.admitted),
  .rsp_last               (result.last)
);

`default_nettype wire
